@@ hdl/led_brightness_animation_controller_macros.svh @@
// assertion macros for the led animation controller
`ifndef LED_BRIGHTNESS_ANIMATION_CONTROLLER_MACROS_SVH
`define LED_BRIGHTNESS_ANIMATION_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/lba_pkg.sv @@
// shared types and constants of the led animation controller
package lba_pkg;
  localparam int LedCountDef = 16;
  localparam int FrameMsDef = 10;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_FLASH = 3'd2;
  localparam logic [2:0] OP_ACT = 3'd3;
  localparam logic [2:0] OP_COLOR = 3'd4;

  localparam logic [1:0] PIX_DARK = 2'd0;
  localparam logic [1:0] PIX_CURSOR = 2'd1;
  localparam logic [1:0] PIX_ALL = 2'd2;

  localparam logic [1:0] REG_IDLE = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_INIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_FIN, ST_OUT
  } lba_state_t;

  typedef struct packed {
    logic exec;
    logic div_start;
    logic div_step;
    logic fin;
  } lba_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } lba_sts_t;
endpackage

@@ hdl/lba_ctrl.sv @@
// controller state machine: sequences one item through the datapath
module lba_ctrl import lba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  lba_sts_t sts,
  output lba_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);
`include "led_brightness_animation_controller_macros.svh"
  lba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = ST_DIV;
        cmd.div_start = 1'b1;
      end
      ST_DIV: begin
        if (!sts.need_div) begin
          state_nxt = ST_OUT;
        end else if (sts.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `LBA_ASSERT_NXT(a_accept_exec, clk, rst_n, in_fire, state_r == ST_EXEC)
  `LBA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !in_fire)
  `LBA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_fire, out_valid)
endmodule

@@ hdl/lba_datapath.sv @@
// datapath: animation state, tick and event logic, serial fade divider
module lba_datapath import lba_pkg::*; #(
  parameter int LED_COUNT = LedCountDef,
  parameter int FRAME_MS = FrameMsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lba_cmd_t    cmd,
  output lba_sts_t    sts,
  input  logic        in_fire,
  input  logic [2:0]  op,
  input  logic        loading_on,
  input  logic [23:0] rgb,
  input  logic [7:0]  flash_level,
  input  logic [15:0] flash_time_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_rdata_idle,
  output logic [15:0] cfg_rdata_step,
  output logic [7:0]  cfg_rdata_init,
  output logic [7:0]  shown_level,
  output logic [23:0] shown_color,
  output logic [1:0]  pixel_mode,
  output logic [7:0]  cursor_pos
);
`include "led_brightness_animation_controller_macros.svh"
  localparam logic [31:0] FrameInc = 32'(FRAME_MS);
  localparam logic [7:0] LastLed = 8'(LED_COUNT - 1);

  logic [31:0] idle_r, idle_nxt;
  logic [15:0] step_r, step_nxt;
  logic [7:0]  init_r, init_nxt;
  logic [31:0] clk_ms_r, clk_ms_nxt;
  logic fading_r, fading_nxt, flash_r, flash_nxt, initd_r, initd_nxt;
  logic swept_r, swept_nxt, loading_r, loading_nxt, puls_r, puls_nxt;
  logic pup_r, pup_nxt, rev_r, rev_nxt;
  logic [7:0]  cur_r, cur_nxt, app_r, app_nxt, ffrom_r, ffrom_nxt, fto_r, fto_nxt;
  logic [31:0] fbeg_r, fbeg_nxt, flb_r, flb_nxt, act_r, act_nxt;
  logic [31:0] lsw_r, lsw_nxt, lpu_r, lpu_nxt;
  logic [15:0] flen_r, flen_nxt, fll_r, fll_nxt;
  logic [23:0] base_r, base_nxt, live_r, live_nxt;
  logic [7:0]  swc_r, swc_nxt, lit_r, lit_nxt;
  logic [1:0]  pix_r, pix_nxt;
  // item fields held from acceptance until the item is executed
  logic [2:0]  op_r, op_nxt;
  logic        lon_r, lon_nxt;
  logic [23:0] rgb_r, rgb_nxt;
  logic [7:0]  flvl_r, flvl_nxt;
  logic [15:0] ftm_r, ftm_nxt;
  // divider
  logic        need_r, need_nxt, neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] num_r, num_nxt;
  logic [15:0] rem_r, rem_nxt;

  // start_fade as a function over a working copy
  function automatic void do_fade(input logic [7:0] tgt, input logic [15:0] len,
                                  input logic [7:0] cl, input logic [31:0] now,
                                  inout logic fd, inout logic [7:0] fr,
                                  inout logic [7:0] to,
                                  inout logic [31:0] bg, inout logic [15:0] ln);
    fr = cl;
    to = tgt;
    if (!fd) bg = now;
    ln = len;
    fd = 1'b1;
  endfunction

  logic [31:0] el;
  logic [8:0]  dmag;
  logic signed [8:0] diff;
  logic [16:0] trial;
  logic [8:0]  stepv;
  logic [8:0]  cura;
  logic        sw_ok;

  always_comb begin
    idle_nxt = idle_r; step_nxt = step_r; init_nxt = init_r;
    clk_ms_nxt = clk_ms_r;
    fading_nxt = fading_r; flash_nxt = flash_r; initd_nxt = initd_r;
    swept_nxt = swept_r; loading_nxt = loading_r; puls_nxt = puls_r;
    pup_nxt = pup_r; rev_nxt = rev_r;
    cur_nxt = cur_r; app_nxt = app_r; ffrom_nxt = ffrom_r; fto_nxt = fto_r;
    fbeg_nxt = fbeg_r; flb_nxt = flb_r; act_nxt = act_r;
    lsw_nxt = lsw_r; lpu_nxt = lpu_r; flen_nxt = flen_r; fll_nxt = fll_r;
    base_nxt = base_r; live_nxt = live_r; swc_nxt = swc_r; lit_nxt = lit_r;
    pix_nxt = pix_r;
    op_nxt = op_r; lon_nxt = lon_r; rgb_nxt = rgb_r; flvl_nxt = flvl_r;
    ftm_nxt = ftm_r;
    need_nxt = need_r; neg_nxt = neg_r; cnt_nxt = cnt_r;
    num_nxt = num_r; rem_nxt = rem_r;
    el = '0; diff = '0; dmag = '0; trial = '0; stepv = '0; cura = '0; sw_ok = 1'b0;

    if (in_fire) begin
      op_nxt = op;
      lon_nxt = loading_on;
      rgb_nxt = rgb;
      flvl_nxt = flash_level;
      ftm_nxt = flash_time_ms;
    end

    if (cfg_we) begin
      case (cfg_idx)
        REG_IDLE: idle_nxt = cfg_wdata;
        REG_STEP: step_nxt = cfg_wdata[15:0];
        REG_INIT: begin
          init_nxt = cfg_wdata[7:0];
          cur_nxt = cfg_wdata[7:0];
          app_nxt = cfg_wdata[7:0];
        end
        default: ;
      endcase
    end

    if (cmd.exec) begin
      need_nxt = 1'b0;
      case (op_r)
        OP_TICK: begin
          clk_ms_nxt = clk_ms_r + FrameInc;
          if (fading_r) begin
            el = clk_ms_nxt - fbeg_r;
            pix_nxt = PIX_ALL;
            if (el <= {16'd0, flen_r}) begin
              if (flen_r == '0) begin
                app_nxt = fto_r;
              end else begin
                // app = from + el*diff/len, done by the serial divider
                diff = $signed({1'b0, fto_r}) - $signed({1'b0, ffrom_r});
                neg_nxt = diff[8];
                dmag = diff[8] ? 9'(-diff) : 9'(diff);
                num_nxt = el[15:0] * dmag[7:0] + (dmag[8] ? {el[15:0], 8'd0} : 24'd0);
                rem_nxt = '0;
                cnt_nxt = 5'd24;
                need_nxt = 1'b1;
              end
            end else begin
              fading_nxt = 1'b0;
              cur_nxt = fto_r;
              app_nxt = fto_r;
            end
          end else if (flash_r) begin
            if (clk_ms_nxt - flb_r >= {16'd0, fll_r}) begin
              flash_nxt = 1'b0;
              fll_nxt = '0;
              live_nxt = base_r;
              pix_nxt = PIX_ALL;
            end
          end else if (!initd_r) begin
            sw_ok = (clk_ms_nxt - lsw_r) >= {16'd0, step_r};
            if (!swept_r && sw_ok) begin
              lsw_nxt = clk_ms_nxt;
              pix_nxt = PIX_CURSOR;
              lit_nxt = swc_r;
              cura = rev_r ? ({1'b0, swc_r} - 9'd1) : ({1'b0, swc_r} + 9'd1);
              if (!cura[8] && cura[7:0] > LastLed) begin
                rev_nxt = 1'b1;
                cura = {1'b0, LastLed};
              end
              if ((cura[8] || cura == '0) && rev_nxt) begin
                app_nxt = '0;
                do_fade(8'd255, 16'd150, cur_nxt, clk_ms_nxt, fading_nxt,
                        ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
                swept_nxt = 1'b1;
                cura = '0;
                rev_nxt = 1'b0;
              end
              swc_nxt = cura[7:0];
            end
            if (swept_nxt && cur_nxt != '0)
              do_fade(8'd0, 16'd3000, cur_nxt, clk_ms_nxt, fading_nxt,
                      ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
            if (clk_ms_nxt > 32'd4000) begin
              initd_nxt = 1'b1;
              puls_nxt = 1'b1;
            end
          end else if (loading_r) begin
            if (cur_r != 8'd250)
              do_fade(8'd250, 16'd50, cur_r, clk_ms_nxt, fading_nxt,
                      ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
            if (cur_r != 8'd1)
              do_fade(8'd1, 16'd50, cur_r, clk_ms_nxt, fading_nxt,
                      ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
          end else if (puls_r) begin
            if (clk_ms_nxt - lpu_r > 32'd100) begin
              lpu_nxt = clk_ms_nxt;
              if (pup_r) begin
                if (cur_r < 8'd100)
                  do_fade(8'd100, 16'd1500, cur_r, clk_ms_nxt, fading_nxt,
                          ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
                else pup_nxt = 1'b0;
              end else begin
                if (cur_r > 8'd10)
                  do_fade(8'd10, 16'd2000, cur_r, clk_ms_nxt, fading_nxt,
                          ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
                else pup_nxt = 1'b1;
              end
            end
          end else if (clk_ms_nxt - act_r >= idle_r) begin
            if (cur_r > 8'd10)
              do_fade(8'd10, 16'd1000, cur_r, clk_ms_nxt, fading_nxt,
                      ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
            else puls_nxt = 1'b1;
          end
        end
        OP_LOAD: begin
          pix_nxt = PIX_ALL;
          if (lon_r) begin
            loading_nxt = 1'b1;
            act_nxt = clk_ms_r;
            puls_nxt = 1'b0;
            fading_nxt = 1'b0;
            live_nxt = {8'd244, 8'd70, 8'd17};
          end else begin
            loading_nxt = 1'b0;
            live_nxt = base_r;
            do_fade(8'd200, 16'd150, cur_r, clk_ms_r, fading_nxt,
                    ffrom_nxt, fto_nxt, fbeg_nxt, flen_nxt);
          end
        end
        OP_FLASH: begin
          puls_nxt = 1'b0;
          fading_nxt = 1'b0;
          flash_nxt = 1'b1;
          fll_nxt = ftm_r;
          flb_nxt = clk_ms_r;
          cur_nxt = flvl_r;
          app_nxt = flvl_r;
          live_nxt = rgb_r;
          pix_nxt = PIX_ALL;
        end
        OP_ACT: begin
          if (!loading_r) act_nxt = clk_ms_r;
          puls_nxt = 1'b0;
          fading_nxt = 1'b0;
          cur_nxt = 8'd255;
          app_nxt = 8'd255;
          pix_nxt = PIX_ALL;
        end
        OP_COLOR: begin
          base_nxt = rgb_r;
          live_nxt = rgb_r;
          pix_nxt = PIX_ALL;
        end
        default: ;
      endcase
    end

    // one quotient bit per step, restoring division of num by flen
    if (cmd.div_step) begin
      trial = {rem_r, num_r[23]};
      if (trial >= {1'b0, flen_r}) begin
        rem_nxt = 16'(trial - {1'b0, flen_r});
        num_nxt = {num_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        num_nxt = {num_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end

    if (cmd.fin) begin
      stepv = num_r[8:0];
      app_nxt = neg_r ? 8'(ffrom_r - stepv[7:0]) : 8'(ffrom_r + stepv[7:0]);
      need_nxt = 1'b0;
    end
  end

  assign sts.need_div = need_r;
  assign sts.div_done = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= 32'd10000; step_r <= 16'd50; init_r <= 8'd255;
      clk_ms_r <= '0;
      fading_r <= 1'b0; flash_r <= 1'b0; initd_r <= 1'b0; swept_r <= 1'b0;
      loading_r <= 1'b0; puls_r <= 1'b0; pup_r <= 1'b1; rev_r <= 1'b0;
      cur_r <= 8'd255; app_r <= 8'd255; ffrom_r <= '0; fto_r <= '0;
      fbeg_r <= '0; flb_r <= '0; act_r <= '0; lsw_r <= '0; lpu_r <= '0;
      flen_r <= '0; fll_r <= '0; base_r <= '0; live_r <= '0;
      swc_r <= '0; lit_r <= '0; pix_r <= PIX_DARK;
      need_r <= 1'b0; cnt_r <= '0;
    end else begin
      idle_r <= idle_nxt; step_r <= step_nxt; init_r <= init_nxt;
      clk_ms_r <= clk_ms_nxt;
      fading_r <= fading_nxt; flash_r <= flash_nxt; initd_r <= initd_nxt;
      swept_r <= swept_nxt; loading_r <= loading_nxt; puls_r <= puls_nxt;
      pup_r <= pup_nxt; rev_r <= rev_nxt;
      cur_r <= cur_nxt; app_r <= app_nxt; ffrom_r <= ffrom_nxt; fto_r <= fto_nxt;
      fbeg_r <= fbeg_nxt; flb_r <= flb_nxt; act_r <= act_nxt;
      lsw_r <= lsw_nxt; lpu_r <= lpu_nxt; flen_r <= flen_nxt; fll_r <= fll_nxt;
      base_r <= base_nxt; live_r <= live_nxt; swc_r <= swc_nxt; lit_r <= lit_nxt;
      pix_r <= pix_nxt;
      need_r <= need_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    op_r <= op_nxt;
    lon_r <= lon_nxt;
    rgb_r <= rgb_nxt;
    flvl_r <= flvl_nxt;
    ftm_r <= ftm_nxt;
  end

  assign cfg_rdata_idle = idle_r;
  assign cfg_rdata_step = step_r;
  assign cfg_rdata_init = init_r;
  assign shown_level = app_r;
  assign shown_color = live_r;
  assign pixel_mode = pix_r;
  assign cursor_pos = (pix_r == PIX_CURSOR) ? lit_r : 8'd0;

  `LBA_ASSERT_IMP(a_step_ok, clk, rst_n, cmd.div_step, need_r && cnt_r != '0)
  `LBA_ASSERT_IMP(a_exec_on_fire, clk, rst_n, in_fire, !cmd.exec)
  `LBA_ASSERT_IMP(a_cursor_range, clk, rst_n, pix_r == PIX_CURSOR, lit_r <= LastLed)
endmodule

@@ hdl/led_brightness_animation_controller.sv @@
// channel     | dir | contents
// in_         | in  | event item: op, loading flag, colour, flash level and time
// out_        | out | shown level, colour, pixel mode, cursor
// cfg_        | in  | apb register port: idle delay, sweep step, initial level
// an event item passes the exec and div states to its result; a fading tick also takes
// the 24 steps of the serial fade divider and a fin state before the result.
// one item at a time: the next item is taken once the result has been accepted.
// reset is synchronous, active low; out_tvalid holds until out_tready.
module led_brightness_animation_controller import lba_pkg::*; #(
  parameter int LED_COUNT = LedCountDef,
  parameter int FRAME_MS = FrameMsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0], loading_on[3], red_in[11:4], green_in[19:12], blue_in[27:20],
  // flash_level[35:28], flash_time_ms[51:36]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // shown_level, shown_red, shown_green, shown_blue, pixel_mode[33:32], cursor_pos[41:34]
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  lba_cmd_t cmd;
  lba_sts_t sts;
  logic busy, in_fire, out_fire, cfg_we;
  logic [31:0] r_idle;
  logic [15:0] r_step;
  logic [7:0]  r_init, lvl, cpos;
  logic [23:0] col;
  logic [1:0]  pm;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_IDLE: cfg_prdata = r_idle;
      REG_STEP: cfg_prdata = {16'd0, r_step};
      REG_INIT: cfg_prdata = {24'd0, r_init};
      default:  cfg_prdata = '0;
    endcase
  end

  lba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  lba_datapath #(.LED_COUNT(LED_COUNT), .FRAME_MS(FRAME_MS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_fire(in_fire),
    .op(in_tdata[2:0]), .loading_on(in_tdata[3]),
    .rgb({in_tdata[11:4], in_tdata[19:12], in_tdata[27:20]}),
    .flash_level(in_tdata[35:28]), .flash_time_ms(in_tdata[51:36]),
    .cfg_we(cfg_we), .cfg_idx(cfg_paddr[3:2]), .cfg_wdata(cfg_pwdata),
    .cfg_rdata_idle(r_idle), .cfg_rdata_step(r_step), .cfg_rdata_init(r_init),
    .shown_level(lvl), .shown_color(col), .pixel_mode(pm), .cursor_pos(cpos)
  );

  assign out_tdata = {6'd0, cpos, pm, col[7:0], col[15:8], col[23:16], lvl};
endmodule

@@ sim/led_brightness_animation_controller_test.sv @@
// testbench for the led animation controller: scoreboard against a behavioral predictor
`timescale 1ns / 100ps

module led_brightness_animation_controller_test;
  import lba_pkg::*;

  localparam int LedCount = LedCountDef;
  localparam int FrameMs = FrameMsDef;
  localparam longint CycleLimit = 4000000;
  localparam int Drain = 40;

  typedef struct {
    logic [2:0] op;
    logic loading_on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] flash_level;
    logic [15:0] flash_time;
  } event_t;

  typedef struct {
    logic [7:0] level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mode;
    logic [7:0] cursor;
  } shown_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [55:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  led_brightness_animation_controller u_top (.*);

  // predicted display state
  logic [31:0] idle_delay;
  logic [15:0] sweep_step;
  logic [7:0] init_level;
  logic [31:0] now_ms;
  logic fading, flashing, init_done, swept, loading, pulsing, pulse_up, reversing;
  logic [7:0] cur_level, app_level, fade_from, fade_to;
  logic [31:0] fade_begin;
  logic [15:0] fade_len;
  logic [31:0] flash_begin;
  logic [15:0] flash_len;
  logic [31:0] last_activity, last_sweep, last_pulse;
  logic [23:0] base_rgb, live_rgb;
  logic [7:0] sweep_pos, lit_pos;
  logic [1:0] pix;

  shown_t pending[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic start_fade(input logic [7:0] target, input logic [15:0] len);
    fade_from = cur_level;
    fade_to = target;
    if (!fading) fade_begin = now_ms;
    fade_len = len;
    fading = 1'b1;
  endtask

  task automatic step_fade();
    logic [31:0] elapsed;
    int diff;
    int part;
    elapsed = now_ms - fade_begin;
    if (elapsed <= {16'd0, fade_len}) begin
      if (fade_len == 16'd0) begin
        app_level = fade_to;
      end else begin
        diff = int'(fade_to) - int'(fade_from);
        part = (int'(elapsed) * diff) / int'(fade_len);
        app_level = 8'(int'(fade_from) + part);
      end
    end else begin
      fading = 1'b0;
      cur_level = fade_to;
      app_level = cur_level;
    end
    pix = PIX_ALL;
  endtask

  task automatic step_sweep();
    int pos;
    if (!swept && (now_ms - last_sweep) >= {16'd0, sweep_step}) begin
      pos = int'(sweep_pos);
      last_sweep = now_ms;
      pix = PIX_CURSOR;
      lit_pos = sweep_pos;
      pos = reversing ? pos - 1 : pos + 1;
      if (pos >= LedCount) begin
        reversing = 1'b1;
        pos = LedCount - 1;
      end
      if (pos <= 0 && reversing) begin
        app_level = 8'd0;
        start_fade(8'd255, 16'd150);
        swept = 1'b1;
        pos = 0;
        reversing = 1'b0;
      end
      sweep_pos = 8'(pos);
    end
    if (swept && cur_level != 8'd0) start_fade(8'd0, 16'd3000);
    if (now_ms > 32'd4000 && !init_done) begin
      init_done = 1'b1;
      pulsing = 1'b1;
    end
  endtask

  task automatic step_frame();
    now_ms += FrameMs;
    if (fading) begin
      step_fade();
    end else if (flashing) begin
      if ((now_ms - flash_begin) >= {16'd0, flash_len}) begin
        flashing = 1'b0;
        flash_len = 16'd0;
        live_rgb = base_rgb;
        pix = PIX_ALL;
      end
    end else if (!init_done) begin
      step_sweep();
    end else if (loading) begin
      if (cur_level != 8'd250) start_fade(8'd250, 16'd50);
      if (cur_level != 8'd1) start_fade(8'd1, 16'd50);
    end else if (pulsing) begin
      if ((now_ms - last_pulse) > 32'd100) begin
        last_pulse = now_ms;
        if (pulse_up) begin
          if (cur_level < 8'd100) start_fade(8'd100, 16'd1500);
          else pulse_up = 1'b0;
        end else begin
          if (cur_level > 8'd10) start_fade(8'd10, 16'd2000);
          else pulse_up = 1'b1;
        end
      end
    end else if ((now_ms - last_activity) >= idle_delay) begin
      if (cur_level > 8'd10) start_fade(8'd10, 16'd1000);
      else pulsing = 1'b1;
    end
  endtask

  task automatic predict_display(input event_t ev, output shown_t res);
    logic [23:0] rgb;
    rgb = {ev.red, ev.green, ev.blue};
    case (ev.op)
      OP_TICK: step_frame();
      OP_LOAD: begin
        if (ev.loading_on) begin
          loading = 1'b1;
          last_activity = now_ms;
          pulsing = 1'b0;
          fading = 1'b0;
          live_rgb = {8'd244, 8'd70, 8'd17};
          pix = PIX_ALL;
        end else begin
          loading = 1'b0;
          live_rgb = base_rgb;
          pix = PIX_ALL;
          start_fade(8'd200, 16'd150);
        end
      end
      OP_FLASH: begin
        pulsing = 1'b0;
        fading = 1'b0;
        flashing = 1'b1;
        flash_len = ev.flash_time;
        flash_begin = now_ms;
        cur_level = ev.flash_level;
        app_level = ev.flash_level;
        live_rgb = rgb;
        pix = PIX_ALL;
      end
      OP_ACT: begin
        if (!loading) last_activity = now_ms;
        pulsing = 1'b0;
        fading = 1'b0;
        cur_level = 8'd255;
        app_level = 8'd255;
        pix = PIX_ALL;
      end
      OP_COLOR: begin
        base_rgb = rgb;
        live_rgb = rgb;
        pix = PIX_ALL;
      end
      default: ;
    endcase
    res.level = app_level;
    res.red = live_rgb[23:16];
    res.green = live_rgb[15:8];
    res.blue = live_rgb[7:0];
    res.mode = pix;
    res.cursor = (pix == PIX_CURSOR) ? lit_pos : 8'd0;
  endtask

  task automatic reset_predictor();
    idle_delay = 32'd10000;
    sweep_step = 16'd50;
    init_level = 8'd255;
    now_ms = '0;
    {fading, flashing, init_done, swept, loading, pulsing, reversing} = '0;
    pulse_up = 1'b1;
    cur_level = init_level;
    app_level = init_level;
    fade_from = '0;
    fade_to = '0;
    fade_begin = '0;
    fade_len = '0;
    flash_begin = '0;
    flash_len = '0;
    last_activity = '0;
    last_sweep = '0;
    last_pulse = '0;
    base_rgb = '0;
    live_rgb = '0;
    sweep_pos = '0;
    lit_pos = '0;
    pix = PIX_DARK;
  endtask

  // one item onto the input stream; prediction happens at acceptance
  task automatic send_item(input event_t ev);
    shown_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {4'd0, ev.flash_time, ev.flash_level, ev.blue, ev.green, ev.red,
                 ev.loading_on, ev.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_display(ev, res);
    pending.push_back(res);
    sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_IDLE: idle_delay = value;
      REG_STEP: sweep_step = value[15:0];
      REG_INIT: begin
        init_level = value[7:0];
        cur_level = init_level;
        app_level = init_level;
      end
      default: ;
    endcase
  endtask

  function automatic event_t make_event(input logic [2:0] op, input logic on,
                                        input logic [23:0] rgb, input logic [7:0] lvl,
                                        input logic [15:0] ms);
    event_t ev;
    ev.op = op;
    ev.loading_on = on;
    {ev.red, ev.green, ev.blue} = rgb;
    ev.flash_level = lvl;
    ev.flash_time = ms;
    return ev;
  endfunction

  function automatic event_t random_event();
    event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    ev = make_event(OP_TICK, 1'($urandom), 24'($urandom), 8'($urandom),
                    16'($urandom_range(0, 300)));
    if ($urandom_range(0, 49) == 0) ev.flash_time = 16'($urandom);
    if (pick < 78) ev.op = OP_TICK;
    else if (pick < 84) ev.op = OP_LOAD;
    else if (pick < 88) ev.op = OP_FLASH;
    else if (pick < 93) ev.op = OP_ACT;
    else if (pick < 98) ev.op = OP_COLOR;
    else ev.op = 3'($urandom_range(5, 7));
    return ev;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_item(random_event());
  endtask

  // result checker and receiver-side stalls
  always @(posedge clk) begin
    shown_t exp_res;
    shown_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[7:0];
        got.red = out_tdata[15:8];
        got.green = out_tdata[23:16];
        got.blue = out_tdata[31:24];
        got.mode = out_tdata[33:32];
        got.cursor = out_tdata[41:34];
        if (pending.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          exp_res = pending.pop_front();
          checked++;
          if (got.level !== exp_res.level) begin
            $error("shown_level exp %0d got %0d", exp_res.level, got.level);
            errors++;
          end
          if (got.red !== exp_res.red) begin
            $error("shown_red exp %0d got %0d", exp_res.red, got.red);
            errors++;
          end
          if (got.green !== exp_res.green) begin
            $error("shown_green exp %0d got %0d", exp_res.green, got.green);
            errors++;
          end
          if (got.blue !== exp_res.blue) begin
            $error("shown_blue exp %0d got %0d", exp_res.blue, got.blue);
            errors++;
          end
          if (got.mode !== exp_res.mode) begin
            $error("pixel_mode exp %0d got %0d", exp_res.mode, got.mode);
            errors++;
          end
          if (got.cursor !== exp_res.cursor) begin
            $error("cursor_pos exp %0d got %0d", exp_res.cursor, got.cursor);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_req--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic test_event_ops();
    send_item(make_event(3'd5, 1'b1, 24'hFFFFFF, 8'hFF, 16'hFFFF));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_COLOR, 1'b0, 24'hFFFFFF, 8'h0, 16'h0));
    send_item(make_event(OP_COLOR, 1'b1, 24'h000000, 8'hFF, 16'hFFFF));
    send_item(make_event(OP_COLOR, 1'b0, 24'hA5C35A, 8'h0, 16'h0));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_FLASH, 1'b0, 24'hFFFFFF, 8'hFF, 16'hFFFF));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_FLASH, 1'b1, 24'h000000, 8'h00, 16'h0000));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_FLASH, 1'b0, 24'h123456, 8'h80, 16'd20));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_LOAD, 1'b1, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_ACT, 1'b0, 24'hFFFFFF, 8'hFF, 16'hFFFF));
    send_item(make_event(OP_LOAD, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(OP_ACT, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(3'd6, 1'b0, 24'h0, 8'h0, 16'h0));
    send_item(make_event(3'd7, 1'b1, 24'h0, 8'h0, 16'h0));
  endtask

  // zero step moves the cursor on every frame, then a long step, then the rest of start-up
  task automatic test_startup_sweep();
    write_reg(REG_STEP, 32'd0);
    repeat (40) send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    write_reg(REG_STEP, 32'd65535);
    repeat (10) send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    write_reg(REG_STEP, 32'd1);
    idle_pct = 79;
    repeat (60) send_item(make_event(OP_TICK, 1'b0, 24'h0, 8'h0, 16'h0));
    idle_pct = 0;
    run_random(400);
  endtask

  task automatic test_random_phases();
    write_reg(REG_IDLE, 32'hFFFFFFFF);
    write_reg(REG_INIT, 32'd255);
    idle_pct = 79;
    stall_pct = 0;
    run_random(300);
    write_reg(REG_IDLE, 32'd0);
    write_reg(REG_INIT, 32'd0);
    write_reg(REG_STEP, 32'd50);
    idle_pct = 0;
    stall_pct = 79;
    run_random(300);
    write_reg(REG_IDLE, 32'($urandom_range(20, 400)));
    write_reg(REG_INIT, 32'($urandom_range(1, 254)));
    idle_pct = 15;
    stall_pct = 15;
    run_random(300);
    idle_pct = 0;
    stall_pct = 0;
    run_random(150);
  endtask

  // receiver holds off, stalling the sender on in_tready, then the sender waits for all results
  task automatic test_backpressure();
    hold_req = 400;
    run_random(30);
    drain_results();
    run_random(40);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_event_ops();
    test_startup_sweep();
    test_random_phases();
    test_backpressure();
    drain_results();
    $display("run covered %0d items and %0d checked results over all event kinds,", sent,
             checked);
    $display("start-up sweep, fades, flashes, loading, pulsing and register extremes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
